@@ hdl/vpa_pkg.sv @@
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the virtual port allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int PORT_W      = 16;
  localparam int OWNER_W     = 8;
  localparam int OP_W        = 2;
  localparam int PORT_SPACE  = 65536;
  localparam int MAX_PROBES  = 35000;
  localparam int PROBE_CNT_W = $clog2(MAX_PROBES + 1);

  localparam logic [PORT_W-1:0] EPHEMERAL_BASE = PORT_W'(30000);
  localparam logic [PORT_W-1:0] RESERVED_RST   = PORT_W'(65535);

  typedef enum logic [OP_W-1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_FIND  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOK   = 4'b0100,
    ST_SEARCH = 4'b1000
  } state_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [PORT_W-1:0]  port;
    logic [OWNER_W-1:0] owner;
  } res_t;

endpackage

@@ hdl/vpa_ram.sv @@
// ----------------------------------------------------------------------------
// vpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/vpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer for the owner table: clearing pass, lookup/update, and the
// one-probe-per-cycle ephemeral port search with its rotating cursor.
// ----------------------------------------------------------------------------
module vpa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vpa_pkg::PORT_W-1:0]    reserved_port,
  input  logic                          in_valid,
  input  logic [vpa_pkg::OP_W-1:0]      in_op,
  input  logic [vpa_pkg::OWNER_W-1:0]   in_owner,
  input  logic [vpa_pkg::PORT_W-1:0]    in_port,
  output logic                          in_ready,
  input  logic                          out_free,
  output vpa_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [vpa_pkg::PORT_W-1:0]    ram_waddr,
  output logic [vpa_pkg::OWNER_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [vpa_pkg::PORT_W-1:0]    ram_raddr,
  input  logic [vpa_pkg::OWNER_W-1:0]   ram_rdata
);
  import vpa_pkg::*;

  state_t                 state, state_next;
  op_t                    op_q, op_q_next;
  logic [OWNER_W-1:0]     owner_q, owner_q_next;
  logic [PORT_W-1:0]      port_q, port_q_next;
  logic [PORT_W-1:0]      cursor, cursor_next;
  logic [PORT_W-1:0]      cand_q, cand_q_next;
  logic [PROBE_CNT_W-1:0] probe_cnt, probe_cnt_next;
  logic                   chk_valid, chk_valid_next;
  logic [PORT_W-1:0]      clr_addr, clr_addr_next;

  logic [PORT_W-1:0]      wrapped;
  logic                   found;
  logic                   issue;

  assign wrapped = (cursor >= reserved_port) ? EPHEMERAL_BASE : cursor;
  assign found   = chk_valid && (cand_q != reserved_port) && (ram_rdata == '0);
  assign issue   = probe_cnt < PROBE_CNT_W'(MAX_PROBES);

  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    owner_q_next   = owner_q;
    port_q_next    = port_q;
    cursor_next    = cursor;
    cand_q_next    = cand_q;
    probe_cnt_next = probe_cnt;
    chk_valid_next = chk_valid;
    clr_addr_next  = clr_addr;
    in_ready       = 1'b0;
    res            = '0;
    ram_we         = 1'b0;
    ram_waddr      = port_q;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = in_port;

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next      = op_t'(in_op);
          owner_q_next   = in_owner;
          port_q_next    = in_port;
          ram_re         = 1'b1;
          probe_cnt_next = '0;
          chk_valid_next = 1'b0;
          if (op_t'(in_op) == OP_REG && in_owner != '0 && in_port == '0) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        // hold the read data until the output register can take the beat
        if (out_free) begin
          res.valid  = 1'b1;
          state_next = ST_IDLE;
          case (op_q)
            OP_REG: begin
              if (owner_q != '0 && port_q != '0 && port_q != reserved_port &&
                  ram_rdata == '0) begin
                ram_we    = 1'b1;
                ram_wdata = owner_q;
                res.ok    = 1'b1;
                res.port  = port_q;
              end
            end
            OP_UNREG: begin
              if (ram_rdata != '0 && ram_rdata == owner_q) begin
                ram_we = 1'b1;
                res.ok = 1'b1;
              end
            end
            OP_FIND: begin
              if (ram_rdata != '0) begin
                res.ok    = 1'b1;
                res.owner = ram_rdata;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // check the last probe issued and, if it missed, issue the next one
        if (found) begin
          if (out_free) begin
            ram_we      = 1'b1;
            ram_waddr   = cand_q;
            ram_wdata   = owner_q;
            res.valid   = 1'b1;
            res.ok      = 1'b1;
            res.port    = cand_q;
            cursor_next = cand_q + 1'b1;
            state_next  = ST_IDLE;
          end
        end else if (issue) begin
          ram_re         = 1'b1;
          ram_raddr      = wrapped;
          cursor_next    = wrapped + 1'b1;
          cand_q_next    = wrapped;
          probe_cnt_next = probe_cnt + 1'b1;
          chk_valid_next = 1'b1;
        end else if (out_free) begin
          res.valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cursor    <= EPHEMERAL_BASE;
      clr_addr  <= '0;
      probe_cnt <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      clr_addr  <= clr_addr_next;
      probe_cnt <= probe_cnt_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    owner_q <= owner_q_next;
    port_q  <= port_q_next;
    cand_q  <= cand_q_next;
  end

  // the table port never reads and writes in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("vpa_ctrl: table read and write in the same cycle");

  assert property (@(posedge clk) disable iff (rst) res.valid |-> out_free)
    else $error("vpa_ctrl: result produced while output register is full");

  assert property (@(posedge clk) disable iff (rst)
      (res.valid && res.ok && op_q == OP_REG) |->
      (res.port != '0 && res.port != reserved_port))
    else $error("vpa_ctrl: granted a null or reserved port");

  assert property (@(posedge clk) disable iff (rst)
      (state == ST_SEARCH && !found && issue) |=> chk_valid)
    else $error("vpa_ctrl: issued probe not marked for checking");

endmodule

@@ hdl/virtual_port_allocator.sv @@
// ----------------------------------------------------------------------------
// virtual_port_allocator
// Port-to-owner table with register / unregister / find and an ephemeral
// port search driven by a rotating cursor.
//
//   channel  dir  handshake          content
//   s_       in   tvalid/tready      tuser: op, tdata: owner_id, port
//   m_       out  tvalid/tready      tuser: ok, tdata: port_out, owner_out
//   cfg_     in   cfg_we             cfg_wdata: reserved_port
//
// After reset the table is swept to zero, one entry a cycle, all 65536
// entries with s_tready low. Unregister, find and register of a given port
// accept with a table read, then check and write back. An ephemeral register
// searches one probe per cycle through the table read port until a probe
// hits; up to 35000 probes. A full output register holds the final cycle
// until m_tready frees it.
// ----------------------------------------------------------------------------
module virtual_port_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] owner_id, [23:8] port
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] port_out, [23:16] owner_out
  output logic        m_tuser    // [0] ok
);
  import vpa_pkg::*;

  logic [PORT_W-1:0]  reserved_port;
  logic               out_free;
  res_t               res;
  logic               ram_we;
  logic [PORT_W-1:0]  ram_waddr;
  logic [OWNER_W-1:0] ram_wdata;
  logic               ram_re;
  logic [PORT_W-1:0]  ram_raddr;
  logic [OWNER_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_port <= RESERVED_RST;
    end else if (cfg_we) begin
      reserved_port <= cfg_wdata;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {res.owner, res.port};
      m_tuser <= res.ok;
    end
  end

  vpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .reserved_port (reserved_port),
    .in_valid      (s_tvalid),
    .in_op         (s_tuser),
    .in_owner      (s_tdata[7:0]),
    .in_port       (s_tdata[23:8]),
    .in_ready      (s_tready),
    .out_free      (out_free),
    .res           (res),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  vpa_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (PORT_SPACE)
  ) u_owner_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ dv/tb_virtual_port_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_virtual_port_allocator
// Self-checking bench for the port allocator. A port table model predicts
// every answer from the accepted request beats and checks the answer beats in
// order. A directed opener covers null owners, the reserved port, taken ports,
// the ephemeral wrap and exhausted searches. Random phases follow, each with
// its own reserved port; all but the last add bursts of idling on both streams.
// ----------------------------------------------------------------------------
module tb_virtual_port_allocator;
  import vpa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;
  localparam int              CYCLE_LIMIT = 1_500_000;
  localparam int              HOLD_CYCLES = 400;
  localparam int              PHASE_BEATS = 250;
  localparam int              SPAN_CAP    = 4000;

  typedef struct {
    bit               ok;
    bit [PORT_W-1:0]  port;
    bit [OWNER_W-1:0] owner;
  } answer_t;

  class port_table_model;
    bit [OWNER_W-1:0] owner_of [PORT_SPACE];
    bit [PORT_W-1:0]  cursor;
    bit [PORT_W-1:0]  reserved;
    answer_t          due [$];
    bit [PORT_W-1:0]  bound_ports [$];
    int               errors;

    function new();
      cursor   = EPHEMERAL_BASE;
      reserved = RESERVED_RST;
      errors   = 0;
    endfunction

    function void set_reserved(bit [PORT_W-1:0] value);
      reserved = value;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    // Free ports the ephemeral search can still reach; wide windows count as plenty.
    function int free_in_window();
      int span;
      int count;
      span  = int'(reserved) - int'(EPHEMERAL_BASE);
      count = 0;
      if (span > SPAN_CAP) begin
        return SPAN_CAP;
      end
      for (int p = int'(EPHEMERAL_BASE); p < int'(reserved); p++) begin
        if (owner_of[PORT_W'(p)] == 0) begin
          count++;
        end
      end
      return count;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [OWNER_W-1:0] owner,
                               logic [PORT_W-1:0] port);
      answer_t         a;
      bit [PORT_W-1:0] chosen;
      bit [PORT_W-1:0] cand;
      a.ok    = 1'b0;
      a.port  = '0;
      a.owner = '0;
      case (op)
        OP_REG: begin
          if (owner != 0) begin
            chosen = port;
            if (chosen == 0) begin
              for (int probe = 0; probe < MAX_PROBES; probe++) begin
                if (cursor >= reserved) begin
                  cursor = EPHEMERAL_BASE;
                end
                cand   = cursor;
                cursor = cursor + 1'b1;
                if (cand != reserved && owner_of[cand] == 0) begin
                  chosen = cand;
                  break;
                end
              end
            end
            if (chosen != 0 && chosen != reserved && owner_of[chosen] == 0) begin
              owner_of[chosen] = owner;
              a.ok   = 1'b1;
              a.port = chosen;
              bound_ports.push_back(chosen);
              if (bound_ports.size() > 256) begin
                void'(bound_ports.pop_front());
              end
            end
          end
        end
        OP_UNREG: begin
          if (owner_of[port] != 0 && owner_of[port] == owner) begin
            owner_of[port] = '0;
            a.ok = 1'b1;
          end
        end
        OP_FIND: begin
          if (owner_of[port] != 0) begin
            a.ok    = 1'b1;
            a.owner = owner_of[port];
          end
        end
        default: ;
      endcase
      due.push_back(a);
    endfunction

    function void check_answer(logic ok, logic [PORT_W-1:0] port,
                               logic [OWNER_W-1:0] owner);
      answer_t a;
      if (due.size() == 0) begin
        $error("answer beat with nothing outstanding: ok %0d port %0d owner %0d",
               ok, port, owner);
        errors++;
        return;
      end
      a = due.pop_front();
      if (ok !== a.ok) begin
        $error("ok: expected %0d, got %0d", a.ok, ok);
        errors++;
      end
      if (port !== a.port) begin
        $error("port_out: expected %0d, got %0d", a.port, port);
        errors++;
      end
      if (owner !== a.owner) begin
        $error("owner_out: expected %0d, got %0d", a.owner, owner);
        errors++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [PORT_W-1:0]   cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata   = '0;   // [7:0] owner_id, [23:8] port
  logic [1:0]          s_tuser   = '0;   // [1:0] op
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [23:0]         m_tdata;          // [15:0] port_out, [23:16] owner_out
  logic                m_tuser;          // [0] ok

  port_table_model ledger = new();
  bit  calm          = 1'b0;
  int  hold_requests = 0;
  int  hold_served   = 0;
  int  hold_left     = 0;
  int  stall_left    = 0;
  int  cycle_count   = 0;

  virtual_port_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_virtual_port_allocator: done, errors");
      $finish;
    end
  end

  // Answer side: long holds on request, short random stalls otherwise.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      ledger.check_answer(m_tuser, m_tdata[15:0], m_tdata[23:16]);
    end
  end

  // Enter and leave at a falling edge; hold tvalid high into the next beat.
  task automatic send_beat(logic [OP_W-1:0] op, logic [OWNER_W-1:0] owner,
                           logic [PORT_W-1:0] port);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {port, owner};
    do @(posedge clk); while (!s_tready);
    ledger.note_request(op, owner, port);
    @(negedge clk);
  endtask

  // Drain every outstanding answer, then write the reserved port.
  task automatic drain_and_write(logic [PORT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_reserved(value);
  endtask

  function automatic logic [OWNER_W-1:0] pick_owner();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return OWNER_W'($urandom_range(1, 6));
    end else if (r < 90) begin
      return '0;
    end
    return OWNER_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PORT_W-1:0] window_port();
    int span;
    span = int'(ledger.reserved) - int'(EPHEMERAL_BASE);
    if (span < 1) begin
      span = 1;
    end else if (span > SPAN_CAP) begin
      span = SPAN_CAP;
    end
    return PORT_W'(int'(EPHEMERAL_BASE) + $urandom_range(0, span));
  endfunction

  function automatic logic [PORT_W-1:0] bound_port();
    if (ledger.bound_ports.size() == 0) begin
      return window_port();
    end
    return ledger.bound_ports[$urandom_range(0, ledger.bound_ports.size() - 1)];
  endfunction

  task automatic random_request(output logic [OP_W-1:0] op,
                                output logic [OWNER_W-1:0] owner,
                                output logic [PORT_W-1:0] port);
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    owner = pick_owner();
    port  = PORT_W'($urandom_range(0, 65535));
    if (r < 40) begin
      op = OP_REG;
      if (s < 45) begin
        // fall back to an explicit port once the ephemeral window is nearly full
        port = (ledger.free_in_window() >= 3) ? '0 : window_port();
      end else if (s < 75) begin
        port = window_port();
      end else if (s < 90) begin
        port = bound_port();
      end
    end else if (r < 65) begin
      op = OP_UNREG;
      if (s < 70) begin
        port  = bound_port();
        owner = ledger.owner_of[port];
      end else if (s < 85) begin
        port = bound_port();
      end
    end else if (r < 95) begin
      op = OP_FIND;
      if (s < 60) begin
        port = bound_port();
      end else if (s < 80) begin
        port = window_port();
      end
    end else begin
      op = OP_SPARE;
    end
  endtask

  initial begin
    logic [OP_W-1:0]    op;
    logic [OWNER_W-1:0] owner;
    logic [PORT_W-1:0]  port;
    logic [PORT_W-1:0]  phase_reserved [4];

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= RESERVED_RST;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_reserved(RESERVED_RST);

    // null owner, reserved port, ephemeral picks that skip a taken port
    send_beat(OP_REG,   8'h00, 16'h0000);
    send_beat(OP_REG,   8'hFF, 16'hFFFF);
    send_beat(OP_REG,   8'h01, 16'h0000);
    send_beat(OP_REG,   8'hFF, 16'h0001);
    send_beat(OP_REG,   8'h02, 16'd30002);
    send_beat(OP_REG,   8'h03, 16'h0000);
    send_beat(OP_REG,   8'h03, 16'h0000);
    send_beat(OP_REG,   8'h04, 16'h0001);
    send_beat(OP_FIND,  8'h00, 16'h0001);
    send_beat(OP_FIND,  8'hFF, 16'hFFFF);
    send_beat(OP_FIND,  8'h00, 16'h0000);
    send_beat(OP_UNREG, 8'h01, 16'h0001);
    send_beat(OP_UNREG, 8'h00, 16'h1234);
    send_beat(OP_UNREG, 8'h00, 16'h0001);
    send_beat(OP_UNREG, 8'hFF, 16'h0001);
    send_beat(OP_SPARE, 8'hAA, 16'h5555);
    send_beat(OP_REG,   8'h80, 16'hFFFE);
    send_beat(OP_FIND,  8'h55, 16'hFFFE);
    send_beat(OP_REG,   8'h05, 16'h0000);

    // smallest legal window: one ephemeral port, taken, so the search runs out
    drain_and_write(16'd30001);
    send_beat(OP_REG,   8'h06, 16'h0000);
    send_beat(OP_REG,   8'h06, 16'd30001);
    send_beat(OP_UNREG, 8'h01, 16'd30000);
    send_beat(OP_REG,   8'h06, 16'h0000);

    // reserved at the ephemeral base: every candidate is the reserved port
    drain_and_write(EPHEMERAL_BASE);
    send_beat(OP_REG,   8'h07, 16'h0000);
    send_beat(OP_REG,   8'h07, EPHEMERAL_BASE);

    // reserved below the base: the cursor keeps snapping back to the base
    drain_and_write(16'h0000);
    send_beat(OP_UNREG, 8'h06, 16'd30000);
    send_beat(OP_REG,   8'h08, 16'h0000);

    phase_reserved[0] = RESERVED_RST;
    phase_reserved[1] = PORT_W'(int'(EPHEMERAL_BASE) + $urandom_range(50, 400));
    phase_reserved[2] = PORT_W'($urandom_range(30001, 65535));
    phase_reserved[3] = PORT_W'(int'(EPHEMERAL_BASE) + $urandom_range(500, 3000));

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(phase_reserved[ph]);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 3) begin
          calm = 1'b1;
        end else if (i % 80 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        if (ph == 1 && i == 40) begin
          hold_requests = hold_requests + 1;
        end
        random_request(op, owner, port);
        send_beat(op, owner, port);
      end
    end

    s_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("tb_virtual_port_allocator: done, clean");
    end else begin
      $display("tb_virtual_port_allocator: done, errors");
    end
    $finish;
  end

endmodule
